/* hdl/cvpf_pkg.sv */
// ----------------------------------------------------------------------------
// cvpf_pkg: shared types and constants for the measurement packet framer
// Field widths, frame constants, register map and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package cvpf_pkg;

  localparam int unsigned PACKET_BYTES = 6;
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned APB_AW       = 4;
  localparam int unsigned APB_DW       = 32;

  localparam logic [BYTE_W-1:0]   START_BYTE    = 8'hA5;
  localparam logic [BYTE_W-1:0]   CRC_POLY      = 8'h07;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE_MV = 12'd3300;
  localparam logic [SAMPLE_W-1:0] ADC_FULL      = 12'hFFF;
  localparam logic [VALUE_W-1:0]  UA_PER_MA     = 16'd1000;

  localparam logic [VALUE_W-1:0]  RST_CUR_DIV  = 16'd100;
  localparam logic [VALUE_W-1:0]  RST_VOLT_MUL = 16'd1;
  localparam logic [VALUE_W-1:0]  RST_VOLT_DIV = 16'd1;

  typedef enum logic [1:0] {
    REG_RAW_MODE = 2'd0,
    REG_CUR_DIV  = 2'd1,
    REG_VOLT_MUL = 2'd2,
    REG_VOLT_DIV = 2'd3
  } cvpf_reg_e;

  typedef enum logic [2:0] {
    SLOT_START   = 3'd0,
    SLOT_VOLT_LO = 3'd1,
    SLOT_VOLT_HI = 3'd2,
    SLOT_CUR_LO  = 3'd3,
    SLOT_CUR_HI  = 3'd4,
    SLOT_CRC     = 3'd5
  } cvpf_slot_e;

  // per-channel scaling set, driven from the register file (current multiplier is UA_PER_MA)
  typedef struct packed {
    logic               raw_mode;
    logic [VALUE_W-1:0] multiplier;
    logic [VALUE_W-1:0] divisor;
  } cvpf_scale_t;

  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/current_voltage_packet_framer_core.sv */
// ----------------------------------------------------------------------------
// current_voltage_packet_framer_core: measurement to framed byte stream
// Converts a current/voltage sample pair and sends it as a CRC-8 frame.
// ----------------------------------------------------------------------------
// Usage:
//   A sample pair is taken at a rising edge with start high and busy low.
//   Each pair gives six words on tx_byte_o, one per cycle, with tx_valid_o
//   high for each of them: 0xA5, voltage lo/hi, current lo/hi, CRC-8.
//   last_byte_o is high with the CRC word.
//   The first word follows the conversion pipeline, the serialiser state and
//   its output register. A new pair is refused while busy is high; busy rises
//   with an accept and holds until the gap counter, sized to the frame, runs out.
//   The conversion pipeline (nine stages, four of them a 4-bit-a-stage
//   divider) overlaps the serialisation of the previous frame.
//   The receiver cannot stall; words are not held.
//   Registers sit on the APB port at 4*index; reset loads raw_mode 0,
//   current_divisor 100, voltage_multiplier 1, voltage_divisor 1.
//   Reset clears all pipeline valid bits; no frame is in flight after it.
//   Users must write registers only while no frame is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module current_voltage_packet_framer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [cvpf_pkg::SAMPLE_W-1:0]     current_raw_i,
  input  logic [cvpf_pkg::SAMPLE_W-1:0]     voltage_raw_i,
  output logic                              tx_valid_o,
  output logic [cvpf_pkg::BYTE_W-1:0]       tx_byte_o,
  output logic                              last_byte_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cvpf_pkg::APB_AW-1:0]       paddr,
  input  logic [cvpf_pkg::APB_DW-1:0]       pwdata,
  output logic [cvpf_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import cvpf_pkg::*;

  localparam logic [2:0] GAP_CYCLES = 3'(PACKET_BYTES - 1);

  // register file
  logic               raw_mode_q;
  logic [VALUE_W-1:0] cur_div_q;
  logic [VALUE_W-1:0] volt_mul_q;
  logic [VALUE_W-1:0] volt_div_q;
  logic               wr_en;
  cvpf_reg_e          reg_sel;

  // input spacing
  logic [2:0]         gap_q, gap_d;
  logic               accept;

  // conversion
  cvpf_scale_t        cur_scale, volt_scale;
  logic               cur_valid, volt_valid;
  logic [VALUE_W-1:0] cur_value, volt_value;

  // serialiser
  logic               active_q, active_d;
  cvpf_slot_e         slot_q, slot_d;
  logic [VALUE_W-1:0] cur_q, volt_q;
  logic [BYTE_W-1:0]  crc_q, crc_d;
  logic [BYTE_W-1:0]  byte_d;
  logic               tx_valid_q;
  logic [BYTE_W-1:0]  tx_byte_q;
  logic               last_q;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = cvpf_reg_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q <= 1'b0;
      cur_div_q  <= RST_CUR_DIV;
      volt_mul_q <= RST_VOLT_MUL;
      volt_div_q <= RST_VOLT_DIV;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RAW_MODE: raw_mode_q <= pwdata[0];
        REG_CUR_DIV:  cur_div_q  <= pwdata[VALUE_W-1:0];
        REG_VOLT_MUL: volt_mul_q <= pwdata[VALUE_W-1:0];
        REG_VOLT_DIV: volt_div_q <= pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_RAW_MODE: prdata = {{(APB_DW-1){1'b0}}, raw_mode_q};
      REG_CUR_DIV:  prdata = {{(APB_DW-VALUE_W){1'b0}}, cur_div_q};
      REG_VOLT_MUL: prdata = {{(APB_DW-VALUE_W){1'b0}}, volt_mul_q};
      REG_VOLT_DIV: prdata = {{(APB_DW-VALUE_W){1'b0}}, volt_div_q};
      default:      prdata = '0;
    endcase
  end

  // pairs enter at most once per frame length, so frames never overlap
  assign busy   = (gap_q != 3'd0);
  assign accept = start & ~busy;

  always_comb begin
    if (accept) begin
      gap_d = GAP_CYCLES;
    end else if (busy) begin
      gap_d = gap_q - 3'd1;
    end else begin
      gap_d = gap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 3'd0;
    end else begin
      gap_q <= gap_d;
    end
  end

  assign cur_scale  = '{raw_mode: raw_mode_q, multiplier: UA_PER_MA, divisor: cur_div_q};
  assign volt_scale = '{raw_mode: raw_mode_q, multiplier: volt_mul_q, divisor: volt_div_q};

  cvpf_conv u_cur_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .sample_i (current_raw_i),
    .scale_i  (cur_scale),
    .valid_o  (cur_valid),
    .value_o  (cur_value)
  );

  cvpf_conv u_volt_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .sample_i (voltage_raw_i),
    .scale_i  (volt_scale),
    .valid_o  (volt_valid),
    .value_o  (volt_value)
  );

  // word currently due, CRC folded in one word per cycle
  always_comb begin
    unique case (slot_q)
      SLOT_START:   byte_d = START_BYTE;
      SLOT_VOLT_LO: byte_d = volt_q[BYTE_W-1:0];
      SLOT_VOLT_HI: byte_d = volt_q[VALUE_W-1:BYTE_W];
      SLOT_CUR_LO:  byte_d = cur_q[BYTE_W-1:0];
      SLOT_CUR_HI:  byte_d = cur_q[VALUE_W-1:BYTE_W];
      SLOT_CRC:     byte_d = crc_q;
      default:      byte_d = crc_q;
    endcase
  end

  always_comb begin
    // a new frame may load on the edge that sends the old CRC
    if (cur_valid & volt_valid) begin
      active_d = 1'b1;
      slot_d   = SLOT_START;
      crc_d    = '0;
    end else if (active_q) begin
      active_d = (slot_q != SLOT_CRC);
      slot_d   = (slot_q == SLOT_CRC) ? SLOT_START : cvpf_slot_e'(slot_q + 3'd1);
      crc_d    = crc8_update(crc_q, byte_d);
    end else begin
      active_d = 1'b0;
      slot_d   = slot_q;
      crc_d    = crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      slot_q     <= SLOT_START;
      tx_valid_q <= 1'b0;
    end else begin
      active_q   <= active_d;
      slot_q     <= slot_d;
      tx_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q     <= crc_d;
    tx_byte_q <= byte_d;
    last_q    <= active_q & (slot_q == SLOT_CRC);
    if (cur_valid & volt_valid) begin
      cur_q  <= cur_value;
      volt_q <= volt_value;
    end
  end

  assign tx_valid_o  = tx_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;

endmodule

/* hdl/cvpf_conv.sv */
// ----------------------------------------------------------------------------
// cvpf_conv: one channel of sample conversion
// ADC code to millivolts, scale, then saturating divide (raw code in raw mode); nine register stages.
// ----------------------------------------------------------------------------
module cvpf_conv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [cvpf_pkg::SAMPLE_W-1:0]   sample_i,
  input  cvpf_pkg::cvpf_scale_t           scale_i,
  output logic                            valid_o,
  output logic [cvpf_pkg::VALUE_W-1:0]    value_o
);
  import cvpf_pkg::*;

  localparam int unsigned PROD_W     = 2 * SAMPLE_W;
  localparam int unsigned NUM_W      = SAMPLE_W + VALUE_W;
  localparam int unsigned REM_W      = VALUE_W + 1;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS  = VALUE_W / DIV_STAGES;

  // stage 1: code times reference
  logic                 v1_q;
  logic [PROD_W-1:0]    prod_q;
  logic [SAMPLE_W-1:0]  raw1_q;
  // stage 2: millivolts
  logic                 v2_q;
  logic [SAMPLE_W-1:0]  mv_q, mv_d;
  logic [SAMPLE_W-1:0]  raw2_q;
  // stage 3: scaled numerator
  logic                 v3_q;
  logic [NUM_W-1:0]     num_q;
  logic [SAMPLE_W-1:0]  raw3_q;
  // division stages, entry 0 is the set-up stage
  logic                 dv_q   [DIV_STAGES+1];
  logic [REM_W-1:0]     drem_q [DIV_STAGES+1];
  logic [REM_W-1:0]     drem_d [DIV_STAGES];
  logic [VALUE_W-1:0]   dnum_q [DIV_STAGES+1];
  logic [VALUE_W-1:0]   dnum_d [DIV_STAGES];
  logic [VALUE_W-1:0]   dquo_q [DIV_STAGES+1];
  logic [VALUE_W-1:0]   dquo_d [DIV_STAGES];
  logic                 dovf_q [DIV_STAGES+1];
  logic [SAMPLE_W-1:0]  draw_q [DIV_STAGES+1];
  // output
  logic                 vo_q;
  logic [VALUE_W-1:0]   value_q;

  // floor(x/4095): x>>12 is low by at most one
  logic [SAMPLE_W-1:0]  q_est;
  logic [SAMPLE_W:0]    r_est;

  always_comb begin
    q_est = prod_q[PROD_W-1:SAMPLE_W];
    r_est = {1'b0, prod_q[SAMPLE_W-1:0]} + {1'b0, q_est};
    mv_d  = (r_est >= {1'b0, ADC_FULL}) ? q_est + 1'b1 : q_est;
  end

  always_comb begin
    logic [REM_W-1:0]   rem;
    logic [VALUE_W-1:0] num;
    logic [VALUE_W-1:0] quo;
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem = drem_q[k];
      num = dnum_q[k];
      quo = dquo_q[k];
      for (int b = 0; b < DIV_STEPS; b++) begin
        rem = {rem[REM_W-2:0], num[VALUE_W-1]};
        num = {num[VALUE_W-2:0], 1'b0};
        if (rem >= {1'b0, scale_i.divisor}) begin
          rem = rem - {1'b0, scale_i.divisor};
          quo = {quo[VALUE_W-2:0], 1'b1};
        end else begin
          quo = {quo[VALUE_W-2:0], 1'b0};
        end
      end
      drem_d[k] = rem;
      dnum_d[k] = num;
      dquo_d[k] = quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      dv_q[0] <= v3_q;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_q[k+1] <= dv_q[k];
      end
      vo_q <= dv_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * FULL_SCALE_MV;
    raw1_q <= sample_i;
    mv_q   <= mv_d;
    raw2_q <= raw1_q;
    num_q  <= mv_q * scale_i.multiplier;
    raw3_q <= raw2_q;
    // quotient overflows 16 bits exactly when num >= divisor << 16
    dovf_q[0] <= ({{(VALUE_W+VALUE_W-NUM_W){1'b0}}, num_q} >= {scale_i.divisor, {VALUE_W{1'b0}}});
    drem_q[0] <= {{(REM_W-SAMPLE_W){1'b0}}, num_q[NUM_W-1:VALUE_W]};
    dnum_q[0] <= num_q[VALUE_W-1:0];
    dquo_q[0] <= '0;
    draw_q[0] <= raw3_q;
    for (int k = 0; k < DIV_STAGES; k++) begin
      drem_q[k+1] <= drem_d[k];
      dnum_q[k+1] <= dnum_d[k];
      dquo_q[k+1] <= dquo_d[k];
      dovf_q[k+1] <= dovf_q[k];
      draw_q[k+1] <= draw_q[k];
    end
    if (scale_i.raw_mode) begin
      value_q <= {{(VALUE_W-SAMPLE_W){1'b0}}, draw_q[DIV_STAGES]};
    end else if (dovf_q[DIV_STAGES]) begin
      value_q <= '1;
    end else begin
      value_q <= dquo_q[DIV_STAGES];
    end
  end

  assign valid_o = vo_q;
  assign value_o = value_q;

endmodule
